FILE: hw/rtl/point_cloud_depth_projector_assert.svh
// Assertion macros shared by the depth projector RTL.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef POINT_CLOUD_DEPTH_PROJECTOR_ASSERT_SVH
`define POINT_CLOUD_DEPTH_PROJECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCDP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("depth projector assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("depth projector assertion failed");

`endif

FILE: hw/rtl/pcdp_pkg.sv
// Package for the point cloud depth projector: word types and fixed codes.
// Depends on nothing; used by pcdp_divider and point_cloud_depth_projector.
`default_nettype none

package pcdp_pkg;

    // Command word fields.
    typedef struct packed {
        logic        [1:0]  opcode;
        logic signed [15:0] point_x_mm;
        logic signed [15:0] point_y_mm;
        logic signed [15:0] point_z_mm;
        logic        [8:0]  read_row;
        logic        [7:0]  read_col;
    } cmd_t;

    // Result word fields.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] pixel_value;
    } result_t;

    // Status from the divider back to the controller.
    typedef struct packed {
        logic done;
        logic overflow;
    } div_stat_t;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PLOT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_OUTSIDE = 2'd1;
    localparam logic [1:0] STAT_BEHIND  = 2'd2;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE    = 3'd4;

    localparam logic [23:0] FOCAL_X_RST  = 24'd65536;
    localparam logic [23:0] FOCAL_Y_RST  = 24'd65536;
    localparam logic [23:0] CENTRE_X_RST = 24'd40960;
    localparam logic [23:0] CENTRE_Y_RST = 24'd23040;
    localparam logic [15:0] RANGE_RST    = 16'd4500;

    // Divider operand widths: projected magnitude after dropping 8 fraction
    // bits, and a divisor that is either Z or the depth range.
    localparam int unsigned DIV_DVD_W = 32;
    localparam int unsigned DIV_DSR_W = 16;

endpackage

`default_nettype wire

FILE: hw/rtl/pcdp_divider.sv
// Radix-2 restoring divider with a bounded quotient width and overflow flag.
// Depends on pcdp_pkg for operand widths and the status struct.
`default_nettype none

module pcdp_divider #(
    parameter int unsigned QUO_W = 10
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [pcdp_pkg::DIV_DVD_W-1:0]   dividend,
    input  wire logic [pcdp_pkg::DIV_DSR_W-1:0]   divisor,
    output logic      [QUO_W-1:0]                 quotient,
    output pcdp_pkg::div_stat_t                   stat
);

    localparam int unsigned SH_W = (pcdp_pkg::DIV_DVD_W > pcdp_pkg::DIV_DSR_W + QUO_W) ?
                                   pcdp_pkg::DIV_DVD_W : pcdp_pkg::DIV_DSR_W + QUO_W;
    localparam int unsigned CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SH_W-1:0]  rem_reg;
    logic [SH_W-1:0]  dsr_reg;
    logic [QUO_W-1:0] quo_reg;

    logic             ovf_start;
    logic             take;

    // The quotient would not fit when the dividend reaches divisor * 2^QUO_W.
    assign ovf_start = SH_W'(dividend) >= (SH_W'(divisor) << QUO_W);
    assign take      = rem_reg >= dsr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // Run the full count even on overflow so both units stay in step.
                busy_reg <= 1'b1;
                ovf_reg  <= ovf_start;
                cnt_reg  <= CNT_W'(QUO_W - 1);
                rem_reg  <= SH_W'(dividend);
                dsr_reg  <= SH_W'(divisor) << (QUO_W - 1);
                quo_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (take)
                begin
                    rem_reg <= rem_reg - dsr_reg;
                end
                quo_reg <= {quo_reg[QUO_W-2:0], take};
                dsr_reg <= dsr_reg >> 1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign quotient      = quo_reg;
    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/point_cloud_depth_projector.sv
// Plot and read: one command at a time. A read addresses, reads and answers. A plot multiplies,
// sums, takes magnitudes and divides for row and column, answering there if outside, else it
// divides for depth unless beyond range, forms the address and writes. Row and column use two
// restoring dividers, depth reuses the first, one bit per cycle. Z <= 0, an unused opcode or
// a read outside the image answer from idle. Clear sweeps the pixel memory at one pixel per
// cycle; after rst_n the same sweep runs with busy high. Results are strobed, never stalled.
`default_nettype none

`include "point_cloud_depth_projector_assert.svh"

// Depends on pcdp_pkg for word types and codes, on pcdp_divider and on the assertion macros.
module point_cloud_depth_projector #(
    parameter int unsigned IMAGE_ROWS = 320,
    parameter int unsigned IMAGE_COLS = 180
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Command channel: a word is taken when start is high and busy is low.
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire pcdp_pkg::cmd_t                       cmd,
    // Result channel: one word per command, valid for the single cycle done is high.
    output logic                                      done,
    output pcdp_pkg::result_t                         result,
    // Register write channel.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [pcdp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pcdp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Quotient width must exceed every valid coordinate so that any value at
    // or beyond the image size is still seen as such; the depth division
    // needs eight bits.
    localparam int unsigned DIM_MAX   = (IMAGE_ROWS > IMAGE_COLS) ? IMAGE_ROWS : IMAGE_COLS;
    localparam int unsigned QUO_W_RAW = $clog2(DIM_MAX) + 1;
    localparam int unsigned QUO_W     = (QUO_W_RAW > 8) ? QUO_W_RAW : 8;
    localparam int unsigned NPIX      = IMAGE_ROWS * IMAGE_COLS;
    localparam int unsigned ADDR_W    = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NPIX - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(IMAGE_COLS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_SUM,
        S_ABS,
        S_DSTART,
        S_COORD,
        S_DSTART2,
        S_DEPTH,
        S_ADDR,
        S_WRITE,
        S_RDADDR,
        S_READ
    } state_t;

    // Configuration registers.
    logic [23:0] focal_x_reg;
    logic [23:0] focal_y_reg;
    logic [23:0] centre_x_reg;
    logic [23:0] centre_y_reg;
    logic [15:0] range_reg;

    // Controller state and result registers.
    state_t            state_reg;
    logic              done_reg;
    pcdp_pkg::result_t result_reg;
    logic              clr_report_reg;
    logic [ADDR_W-1:0] addr_reg;

    // Plot datapath registers.
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic        [14:0] z_reg;
    logic signed [40:0] prod_fx_reg;
    logic signed [40:0] prod_fy_reg;
    logic        [38:0] prod_cx_reg;
    logic        [38:0] prod_cy_reg;
    logic        [41:0] num_x_reg;
    logic        [41:0] num_y_reg;
    logic        [31:0] dvd_x_reg;
    logic        [31:0] dvd_y_reg;
    logic               neg_x_reg;
    logic               neg_y_reg;
    logic        [23:0] dep_num_reg;
    logic               z_lt_r_reg;
    logic [QUO_W-1:0]   row_reg;
    logic [QUO_W-1:0]   col_reg;
    logic [7:0]         pix_val_reg;

    // Pixel memory and its registered read data.
    logic [7:0] pixel_mem [0:NPIX-1];
    logic [7:0] rdata_reg;
    logic       mem_we;
    logic       mem_re;
    logic [7:0] mem_wdata;

    // Divider hookup.
    logic                                 div_a_start;
    logic                                 div_b_start;
    logic [pcdp_pkg::DIV_DVD_W-1:0]       div_a_dvd;
    logic [pcdp_pkg::DIV_DSR_W-1:0]       div_a_dsr;
    logic [pcdp_pkg::DIV_DSR_W-1:0]       z_dsr;
    logic [QUO_W-1:0]                     div_a_quo;
    logic [QUO_W-1:0]                     div_b_quo;
    pcdp_pkg::div_stat_t                  div_a_stat;
    pcdp_pkg::div_stat_t                  div_b_stat;

    logic accept;
    logic z_pos;
    logic rd_inside;
    logic row_ok;
    logic col_ok;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign z_pos     = !cmd.point_z_mm[15] && (cmd.point_z_mm != 16'sd0);
    assign rd_inside = (32'(cmd.read_row) < IMAGE_ROWS) && (32'(cmd.read_col) < IMAGE_COLS);

    // A negative numerator truncates toward zero, so it lands on index zero
    // only when its magnitude stays below one full pixel.
    assign row_ok = !div_a_stat.overflow &&
                    (neg_x_reg ? (div_a_quo == '0) : (32'(div_a_quo) < IMAGE_ROWS));
    assign col_ok = !div_b_stat.overflow &&
                    (neg_y_reg ? (div_b_quo == '0) : (32'(div_b_quo) < IMAGE_COLS));

    // Unit A divides the row and then, when needed, the depth scale; unit B
    // divides the column alongside the row.
    assign z_dsr       = {1'b0, z_reg};
    assign div_a_start = (state_reg == S_DSTART) || (state_reg == S_DSTART2);
    assign div_b_start = (state_reg == S_DSTART);
    assign div_a_dvd   = (state_reg == S_DSTART2) ? pcdp_pkg::DIV_DVD_W'(dep_num_reg) : dvd_x_reg;
    assign div_a_dsr   = (state_reg == S_DSTART2) ? range_reg : z_dsr;

    pcdp_divider #(
        .QUO_W (QUO_W)
    ) u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_a_start),
        .dividend (div_a_dvd),
        .divisor  (div_a_dsr),
        .quotient (div_a_quo),
        .stat     (div_a_stat)
    );

    pcdp_divider #(
        .QUO_W (QUO_W)
    ) u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_b_start),
        .dividend (dvd_y_reg),
        .divisor  (z_dsr),
        .quotient (div_b_quo),
        .stat     (div_b_stat)
    );

    // Register writes; an index past the last register is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= pcdp_pkg::FOCAL_X_RST;
            focal_y_reg  <= pcdp_pkg::FOCAL_Y_RST;
            centre_x_reg <= pcdp_pkg::CENTRE_X_RST;
            centre_y_reg <= pcdp_pkg::CENTRE_Y_RST;
            range_reg    <= pcdp_pkg::RANGE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcdp_pkg::CFG_FOCAL_X:  focal_x_reg  <= cfg_data;
                pcdp_pkg::CFG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                pcdp_pkg::CFG_CENTRE_X: centre_x_reg <= cfg_data;
                pcdp_pkg::CFG_CENTRE_Y: centre_y_reg <= cfg_data;
                pcdp_pkg::CFG_RANGE:    range_reg    <= cfg_data[15:0];
                default:                ;
            endcase
        end
    end

    // The memory has one port: the clear sweep and plots write, reads use
    // the same address register and return registered read data.
    assign mem_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign mem_re    = (state_reg == S_RDADDR);
    assign mem_wdata = (state_reg == S_CLEAR) ? 8'd0 : pix_val_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pixel_mem[addr_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= pixel_mem[addr_reg];
        end
    end

    // Controller and plot datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            clr_report_reg <= 1'b0;
            addr_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    if (addr_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                        // The sweep after reset answers no command.
                        if (clr_report_reg)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{status: pcdp_pkg::STAT_DONE, pixel_value: 8'd0};
                        end
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg <= cmd.point_x_mm;
                        y_reg <= cmd.point_y_mm;
                        z_reg <= cmd.point_z_mm[14:0];
                        case (cmd.opcode)
                            pcdp_pkg::OP_CLEAR:
                            begin
                                addr_reg       <= '0;
                                clr_report_reg <= 1'b1;
                                state_reg      <= S_CLEAR;
                            end
                            pcdp_pkg::OP_PLOT:
                            begin
                                if (z_pos)
                                begin
                                    state_reg <= S_MUL;
                                end
                                else
                                begin
                                    done_reg   <= 1'b1;
                                    result_reg <= '{status: pcdp_pkg::STAT_BEHIND,
                                                    pixel_value: 8'd0};
                                end
                            end
                            pcdp_pkg::OP_READ:
                            begin
                                if (rd_inside)
                                begin
                                    addr_reg  <= ADDR_W'(ADDR_W'(cmd.read_row) * COLS_A +
                                                         ADDR_W'(cmd.read_col));
                                    state_reg <= S_RDADDR;
                                end
                                else
                                begin
                                    done_reg   <= 1'b1;
                                    result_reg <= '{status: pcdp_pkg::STAT_OUTSIDE,
                                                    pixel_value: 8'd0};
                                end
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                result_reg <= '{status: pcdp_pkg::STAT_DONE, pixel_value: 8'd0};
                            end
                        endcase
                    end
                end

                S_MUL:
                begin
                    // Z is known positive here, so its low 15 bits are its value.
                    prod_fx_reg <= $signed({1'b0, focal_x_reg}) * x_reg;
                    prod_fy_reg <= $signed({1'b0, focal_y_reg}) * y_reg;
                    prod_cx_reg <= centre_x_reg * z_reg;
                    prod_cy_reg <= centre_y_reg * z_reg;
                    // Numerator of the rounded-up depth scale: Z*255 + range - 1.
                    dep_num_reg <= 24'({z_reg, 8'd0}) - 24'(z_reg) + 24'(range_reg) - 24'd1;
                    z_lt_r_reg  <= 16'(z_reg) < range_reg;
                    state_reg   <= S_SUM;
                end

                S_SUM:
                begin
                    num_x_reg <= {prod_fx_reg[40], prod_fx_reg} + {3'b000, prod_cx_reg};
                    num_y_reg <= {prod_fy_reg[40], prod_fy_reg} + {3'b000, prod_cy_reg};
                    state_reg <= S_ABS;
                end

                S_ABS:
                begin
                    // Dropping the 8 fraction bits first leaves the floor unchanged.
                    neg_x_reg <= num_x_reg[41];
                    neg_y_reg <= num_y_reg[41];
                    dvd_x_reg <= num_x_reg[41] ? 32'((-num_x_reg) >> 8) : 32'(num_x_reg >> 8);
                    dvd_y_reg <= num_y_reg[41] ? 32'((-num_y_reg) >> 8) : 32'(num_y_reg >> 8);
                    state_reg <= S_DSTART;
                end

                S_DSTART:
                begin
                    state_reg <= S_COORD;
                end

                S_COORD:
                begin
                    if (div_a_stat.done)
                    begin
                        row_reg <= div_a_quo;
                        col_reg <= div_b_quo;
                        if (!(row_ok && col_ok))
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{status: pcdp_pkg::STAT_OUTSIDE, pixel_value: 8'd0};
                            state_reg  <= S_IDLE;
                        end
                        else if (z_lt_r_reg)
                        begin
                            state_reg <= S_DSTART2;
                        end
                        else
                        begin
                            // At or beyond range the pixel saturates to zero.
                            pix_val_reg <= 8'd0;
                            state_reg   <= S_ADDR;
                        end
                    end
                end

                S_DSTART2:
                begin
                    state_reg <= S_DEPTH;
                end

                S_DEPTH:
                begin
                    if (div_a_stat.done)
                    begin
                        pix_val_reg <= 8'd255 - div_a_quo[7:0];
                        state_reg   <= S_ADDR;
                    end
                end

                S_ADDR:
                begin
                    addr_reg  <= ADDR_W'(ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg));
                    state_reg <= S_WRITE;
                end

                S_WRITE:
                begin
                    done_reg   <= 1'b1;
                    result_reg <= '{status: pcdp_pkg::STAT_DONE, pixel_value: pix_val_reg};
                    state_reg  <= S_IDLE;
                end

                S_RDADDR:
                begin
                    state_reg <= S_READ;
                end

                S_READ:
                begin
                    done_reg   <= 1'b1;
                    result_reg <= '{status: pcdp_pkg::STAT_DONE, pixel_value: rdata_reg};
                    state_reg  <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Both coordinate dividers are started together and must finish together.
    `PCDP_ASSERT_IMPLY(a_div_lockstep, clk, rst_n,
        (state_reg == S_COORD) && div_a_stat.done, div_b_stat.done)
    // The clear sweep never steps past the last pixel.
    `PCDP_ASSERT_IMPLY(a_clear_in_range, clk, rst_n, state_reg == S_CLEAR, addr_reg <= LAST_ADDR)
    // A plot write is answered in the next cycle with the value written.
    `PCDP_ASSERT_NEXT(a_write_answers, clk, rst_n, state_reg == S_WRITE,
        done && (result.pixel_value == $past(pix_val_reg)))
    // A dropped point never reports a pixel value.
    `PCDP_ASSERT_IMPLY(a_drop_no_pixel, clk, rst_n,
        done && ((result.status == pcdp_pkg::STAT_OUTSIDE) ||
                 (result.status == pcdp_pkg::STAT_BEHIND)),
        result.pixel_value == 8'd0)

endmodule

`default_nettype wire
